/* design/pts_pkg.sv */
`timescale 1ns / 1ps

package pts_pkg;

    // Field and datapath widths
    localparam int VOLT_W  = 16;
    localparam int PRES_W  = 24;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int CH_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Divider operands: 16x16 product over a 16 bit range
    localparam int DVD_W = 32;
    localparam int DVS_W = 16;

    // Channel count
    localparam int NUM_SENSORS_DEF = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARE_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 2'd3;

    // Register reset values
    localparam logic [CNT_W-1:0]  TARE_SAMPLES_RST = 8'd16;
    localparam logic [VOLT_W-1:0] VOLT_MIN_RST     = 16'd5000;
    localparam logic [VOLT_W-1:0] VOLT_MAX_RST     = 16'd45000;
    localparam logic [VOLT_W-1:0] FULL_SCALE_RST   = 16'd10000;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // take the input beat
        logic prep;       // read channel state, update tare sum/count
        logic div_start;  // load the divider
        logic finish;     // write result register, commit tare
    } pts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } pts_sts_t;

endpackage

/* design/pressure_tare_and_scale.sv */
`timescale 1ns / 1ps
// Pressure transducer front end: per-channel tare averaging and linear scaling.
// Input channel (in_valid/in_stall): kind (0 tare, 1 measure), sensor, voltage.
// Every accepted beat gives exactly one result beat on out_valid/out_stall.
// Config channel (cfg_valid/cfg_ready, cfg_ready always high): cfg_index picks
// tare_samples, volt_min, volt_max or full_scale; write only while idle.
// A division runs for a closing tare sample or a measure sample with a good range;
// a tare sample that does not finish its average, a channel out of range or a
// measure with a bad range goes to the result register without one.
// The division is a radix-2 restoring divider, one quotient bit per cycle over
// 32 bits.
// in_stall is high while an item is in work; the next item is taken as soon as
// the result sits in the output register, even if the receiver stalls it.
// A stalled result holds in the output register; a finished item then waits
// until that register frees, so at most two items are held.
// Reset clears all channel sums, counts and stored tares, loads the register
// defaults and leaves no result pending.
module pressure_tare_and_scale
    import pts_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [CH_W-1:0]       sensor,
    input  logic [VOLT_W-1:0]     voltage,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       sensor_out,
    output logic [PRES_W-1:0]     pressure,
    output logic                  pressure_valid,
    output logic                  tare_done,
    output logic [VOLT_W-1:0]     tare_level,
    output logic                  saturated,
    output logic                  range_error,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pts_cmd_t cmd;
    pts_sts_t sts;

    assign cfg_ready = 1'b1;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_dp #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .sensor         (sensor),
        .voltage        (voltage),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sensor_out     (sensor_out),
        .pressure       (pressure),
        .pressure_valid (pressure_valid),
        .tare_done      (tare_done),
        .tare_level     (tare_level),
        .saturated      (saturated),
        .range_error    (range_error),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // clipping only on a measured pressure, pinned at full code
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> pressure_valid && (pressure == '1))
        else $error("saturated without full-scale pressure");

    // a result is a pressure, a tare completion or a range fault, never two
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pressure_valid && (range_error || tare_done))
                      && !(tare_done && range_error))
        else $error("conflicting result flags");

    // no pressure value without a measured pressure
    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> (pressure == '0) && !saturated)
        else $error("pressure set on non-measure result");
`endif

endmodule

/* design/pts_div.sv */
`timescale 1ns / 1ps

module pts_div
    import pts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVD_W-1:0]  quo_next;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
        rem_next  = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next  = {quo_reg[DVD_W-2:0], fits};
    end

    assign done     = busy_reg && (step_reg == STEP_W'(DVD_W - 1));
    assign quotient = quo_reg;

    // Step counter and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

/* design/pts_dp.sv */
`timescale 1ns / 1ps

module pts_dp
    import pts_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pts_cmd_t              cmd,
    output pts_sts_t              sts,
    // input beat
    input  logic                  kind,
    input  logic [CH_W-1:0]       sensor,
    input  logic [VOLT_W-1:0]     voltage,
    // result beat
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       sensor_out,
    output logic [PRES_W-1:0]     pressure,
    output logic                  pressure_valid,
    output logic                  tare_done,
    output logic [VOLT_W-1:0]     tare_level,
    output logic                  saturated,
    output logic                  range_error,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    // Configuration
    logic [CNT_W-1:0]  tare_samples_reg;
    logic [VOLT_W-1:0] volt_min_reg;
    logic [VOLT_W-1:0] volt_max_reg;
    logic [VOLT_W-1:0] full_scale_reg;

    // Per-channel state
    logic [SUM_W-1:0]  sum_reg   [NUM_SENSORS];
    logic [CNT_W-1:0]  cnt_reg   [NUM_SENSORS];
    logic [VOLT_W-1:0] store_reg [NUM_SENSORS];
    logic              valid_reg [NUM_SENSORS];

    // Captured item and prep results
    logic              kind_reg;
    logic [CH_W-1:0]   sensor_reg;
    logic [VOLT_W-1:0] voltage_reg;
    logic              done_reg;
    logic              rerr_reg;
    logic              need_div_reg;
    logic [SUM_W-1:0]  num_reg;
    logic [DVS_W-1:0]  den_reg;

    // Result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   sensor_out_reg;
    logic [PRES_W-1:0] pressure_reg;
    logic              pvalid_reg;
    logic              tdone_reg;
    logic [VOLT_W-1:0] level_reg;
    logic              sat_reg;
    logic              rerr_out_reg;

    logic              ch_ok;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  need;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              complete;
    logic              range_bad;
    logic [VOLT_W-1:0] zero;
    logic [VOLT_W-1:0] diff;
    logic [DVS_W-1:0]  span;
    logic [DVD_W-1:0]  product;
    logic [DVD_W-1:0]  dividend;
    logic              div_done;
    logic [DVD_W-1:0]  quotient;
    logic              meas_ok;
    logic              sat_next;
    logic [PRES_W-1:0] pressure_next;

    // Channel select
    assign ch_ok = (32'(sensor_reg) < NUM_SENSORS);
    assign idx   = IDX_W'(sensor_reg);

    // Tare accumulate and measure zero point
    always_comb
    begin
        need      = (tare_samples_reg == '0) ? CNT_W'(1) : tare_samples_reg;
        sum_next  = sum_reg[idx] + SUM_W'(voltage_reg);
        cnt_next  = cnt_reg[idx] + 1'b1;
        complete  = (cnt_next >= need) && (cnt_next != '0);
        range_bad = (volt_max_reg <= volt_min_reg);
        zero      = valid_reg[idx] ? store_reg[idx] : volt_min_reg;
        diff      = (voltage_reg > zero) ? (voltage_reg - zero) : '0;
        span      = volt_max_reg - volt_min_reg;
    end

    // Scale multiply feeds the divider load directly
    assign product  = DVD_W'(full_scale_reg) * DVD_W'(num_reg[VOLT_W-1:0]);
    assign dividend = kind_reg ? product : DVD_W'(num_reg);

    pts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Result fields
    always_comb
    begin
        meas_ok       = ch_ok && kind_reg && !rerr_reg;
        sat_next      = meas_ok && (quotient[DVD_W-1:PRES_W] != '0);
        pressure_next = '0;
        if (meas_ok)
            pressure_next = sat_next ? '1 : quotient[PRES_W-1:0];
    end

    always_comb
    begin
        sts.need_div = need_div_reg;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || !out_stall;
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_samples_reg <= TARE_SAMPLES_RST;
            volt_min_reg     <= VOLT_MIN_RST;
            volt_max_reg     <= VOLT_MAX_RST;
            full_scale_reg   <= FULL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARE_SAMPLES: tare_samples_reg <= cfg_data[CNT_W-1:0];
                REG_VOLT_MIN:     volt_min_reg     <= cfg_data[VOLT_W-1:0];
                REG_VOLT_MAX:     volt_max_reg     <= cfg_data[VOLT_W-1:0];
                REG_FULL_SCALE:   full_scale_reg   <= cfg_data[VOLT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Channel state: sum/count at prep, stored tare at finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                sum_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
                store_reg[i] <= '0;
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.prep && ch_ok && !kind_reg)
            begin
                sum_reg[idx] <= complete ? '0 : sum_next;
                cnt_reg[idx] <= complete ? '0 : cnt_next;
            end
            if (cmd.finish && done_reg)
            begin
                store_reg[idx] <= quotient[VOLT_W-1:0];
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    // Item capture and prep latches
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= kind;
            sensor_reg  <= sensor;
            voltage_reg <= voltage;
        end
        if (cmd.prep)
        begin
            done_reg     <= ch_ok && !kind_reg && complete;
            rerr_reg     <= ch_ok && kind_reg && range_bad;
            need_div_reg <= ch_ok && (kind_reg ? !range_bad : complete);
            num_reg      <= kind_reg ? SUM_W'(diff) : sum_next;
            den_reg      <= kind_reg ? span : DVS_W'(cnt_next);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            sensor_out_reg <= sensor_reg;
            pressure_reg   <= pressure_next;
            pvalid_reg     <= meas_ok;
            tdone_reg      <= done_reg;
            level_reg      <= done_reg ? quotient[VOLT_W-1:0] : '0;
            sat_reg        <= sat_next;
            rerr_out_reg   <= rerr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sensor_out     = sensor_out_reg;
    assign pressure       = pressure_reg;
    assign pressure_valid = pvalid_reg;
    assign tare_done      = tdone_reg;
    assign tare_level     = level_reg;
    assign saturated      = sat_reg;
    assign range_error    = rerr_out_reg;

endmodule

/* design/pts_ctrl.sv */
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pts_sts_t sts,
    output pts_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequencer: one item in flight
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sim/pts_checker.sv */
`timescale 1ns / 1ps

// Sample kind codes shared by the checker and the stimulus
package pts_tb_pkg;

    localparam logic KIND_TARE    = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

endpackage

// Watches the sample, result and register channels, keeps its own copy of the
// per-channel tare state and calibration, and checks every result beat in order.
module pts_checker
    import pts_pkg::*;
    import pts_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  kind,
    input  logic [CH_W-1:0]       sensor,
    input  logic [VOLT_W-1:0]     voltage,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CH_W-1:0]       sensor_out,
    input  logic [PRES_W-1:0]     pressure,
    input  logic                  pressure_valid,
    input  logic                  tare_done,
    input  logic [VOLT_W-1:0]     tare_level,
    input  logic                  saturated,
    input  logic                  range_error,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count,
    output int                    checked_count
);

    localparam logic [PRES_W-1:0] PRES_CEIL = '1;

    typedef struct packed {
        logic [CH_W-1:0]   sensor;
        logic [PRES_W-1:0] pressure;
        logic              pvalid;
        logic              done;
        logic [VOLT_W-1:0] level;
        logic              sat;
        logic              rerr;
    } reading_t;

    // Per-channel tare accumulation and stored zero points
    logic [SUM_W-1:0]  acc_sum    [NUM_SENSORS_DEF];
    logic [CNT_W-1:0]  acc_count  [NUM_SENSORS_DEF];
    logic [VOLT_W-1:0] zero_level [NUM_SENSORS_DEF];
    logic              zero_known [NUM_SENSORS_DEF];

    // Calibration copy
    logic [CNT_W-1:0]  avg_len;
    logic [VOLT_W-1:0] v_lo;
    logic [VOLT_W-1:0] v_hi;
    logic [VOLT_W-1:0] span_pres;

    reading_t expected_readings[$];
    reading_t want;
    int       errors;
    int       checked;

    // Predict one result beat and update the channel state
    function automatic reading_t convert_sample(input logic k, input logic [CH_W-1:0] ch,
                                                input logic [VOLT_W-1:0] v);
        reading_t          r;
        logic [CNT_W-1:0]  need;
        logic [VOLT_W-1:0] zero;
        logic [VOLT_W-1:0] avg;
        logic [31:0]       diff;
        logic [31:0]       product;
        logic [31:0]       quotient;
        r = '0;
        r.sensor = ch;
        if (ch < NUM_SENSORS_DEF) begin
            if (k == KIND_TARE) begin
                // zero sample count behaves as one
                need = (avg_len == '0) ? CNT_W'(1) : avg_len;
                acc_sum[ch] = acc_sum[ch] + SUM_W'(v);
                acc_count[ch] = acc_count[ch] + 1'b1;
                // count may already be past a lowered target
                if (acc_count[ch] >= need && acc_count[ch] != '0) begin
                    avg = VOLT_W'(acc_sum[ch] / SUM_W'(acc_count[ch]));
                    zero_level[ch] = avg;
                    zero_known[ch] = 1'b1;
                    acc_sum[ch] = '0;
                    acc_count[ch] = '0;
                    r.done = 1'b1;
                    r.level = avg;
                end
            end
            else if (v_hi <= v_lo) begin
                r.rerr = 1'b1;
            end
            else begin
                zero = zero_known[ch] ? zero_level[ch] : v_lo;
                diff = (v > zero) ? 32'(v - zero) : 32'd0;
                product = 32'(span_pres) * diff;
                quotient = product / 32'(v_hi - v_lo);
                if (quotient > 32'(PRES_CEIL)) begin
                    r.pressure = PRES_CEIL;
                    r.sat = 1'b1;
                end
                else begin
                    r.pressure = PRES_W'(quotient);
                end
                r.pvalid = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic compare(input string what, input longint unsigned exp_val,
                           input longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
            errors++;
        end
    endtask

    // Results are popped before new samples are pushed in the same cycle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_SENSORS_DEF; i++) begin
                acc_sum[i] = '0;
                acc_count[i] = '0;
                zero_level[i] = '0;
                zero_known[i] = 1'b0;
            end
            avg_len = TARE_SAMPLES_RST;
            v_lo = VOLT_MIN_RST;
            v_hi = VOLT_MAX_RST;
            span_pres = FULL_SCALE_RST;
            expected_readings.delete();
            errors = 0;
            checked = 0;
            fail_count <= 0;
            pending_count <= 0;
            checked_count <= 0;
        end
        else begin
            // result beat
            if (out_valid && !out_stall) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result beat for sensor %0d, expected none, got one",
                             $time, sensor_out);
                    errors++;
                end
                else begin
                    want = expected_readings.pop_front();
                    compare("sensor_out", want.sensor, sensor_out);
                    compare("pressure", want.pressure, pressure);
                    compare("pressure_valid", want.pvalid, pressure_valid);
                    compare("tare_done", want.done, tare_done);
                    compare("tare_level", want.level, tare_level);
                    compare("saturated", want.sat, saturated);
                    compare("range_error", want.rerr, range_error);
                    checked++;
                end
            end

            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TARE_SAMPLES: avg_len = cfg_data[CNT_W-1:0];
                    REG_VOLT_MIN:     v_lo = cfg_data[VOLT_W-1:0];
                    REG_VOLT_MAX:     v_hi = cfg_data[VOLT_W-1:0];
                    REG_FULL_SCALE:   span_pres = cfg_data[VOLT_W-1:0];
                    default:          ;
                endcase
            end

            // sample beat
            if (in_valid && !in_stall) begin
                expected_readings.push_back(convert_sample(kind, sensor, voltage));
            end

            fail_count <= errors;
            pending_count <= expected_readings.size();
            checked_count <= checked;
        end
    end

endmodule

/* sim/pressure_tare_and_scale_test.sv */
`timescale 1ns / 1ps

module pressure_tare_and_scale_test;

    import pts_pkg::*;
    import pts_tb_pkg::*;

    localparam int RUN_LIMIT         = 500000;
    localparam int SAMPLES_PER_SETUP = 50;
    localparam int RANDOM_SETUPS     = 8;
    localparam int DRAIN_CYCLES      = 40;

    typedef enum {FLOW, JITTER, HOLD} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [CH_W-1:0]       sensor;
    logic [VOLT_W-1:0]     voltage;
    logic                  out_valid;
    logic                  out_stall;
    logic [CH_W-1:0]       sensor_out;
    logic [PRES_W-1:0]     pressure;
    logic                  pressure_valid;
    logic                  tare_done;
    logic [VOLT_W-1:0]     tare_level;
    logic                  saturated;
    logic                  range_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int results_waiting;
    int results_checked;

    int cycle_count  = 0;
    int burst_left   = 0;
    int tare_sent    = 0;
    int measure_sent = 0;
    int setup_count  = 0;
    int reg_writes   = 0;
    int cur_lo       = VOLT_MIN_RST;
    int cur_hi       = VOLT_MAX_RST;
    int cur_len      = TARE_SAMPLES_RST;

    stall_mode_t stall_mode = FLOW;
    int          stall_left = 0;

    pressure_tare_and_scale i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .sensor         (sensor),
        .voltage        (voltage),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sensor_out     (sensor_out),
        .pressure       (pressure),
        .pressure_valid (pressure_valid),
        .tare_done      (tare_done),
        .tare_level     (tare_level),
        .saturated      (saturated),
        .range_error    (range_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    pts_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .sensor         (sensor),
        .voltage        (voltage),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sensor_out     (sensor_out),
        .pressure       (pressure),
        .pressure_valid (pressure_valid),
        .tare_done      (tare_done),
        .tare_level     (tare_level),
        .saturated      (saturated),
        .range_error    (range_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (mismatches),
        .pending_count  (results_waiting),
        .checked_count  (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("pressure_tare_and_scale_test failed");
            $finish;
        end
    end

    // Result back-pressure: free flow, random jitter or solid holds
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_left = $urandom_range(1, 40);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            FLOW:    out_stall <= 1'b0;
            JITTER:  out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= 1'b1;
        endcase
    end

    // Random value around a center, clamped to the voltage range
    function automatic logic [VOLT_W-1:0] nudge(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[VOLT_W-1:0];
    endfunction

    function automatic logic [VOLT_W-1:0] pick_voltage();
        logic [VOLT_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = nudge(cur_lo, 20);
            3:       v = (cur_hi > cur_lo) ? VOLT_W'($urandom_range(cur_lo, cur_hi))
                                           : VOLT_W'($urandom_range(0, 65535));
            default: v = VOLT_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // One sample beat; bursts of random length separated by random gaps
    task automatic send_sample(input logic k, input logic [CH_W-1:0] s,
                               input logic [VOLT_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        sensor <= s;
        voltage <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (k == KIND_TARE)
            tare_sent++;
        else
            measure_sent++;
    endtask

    // Wait until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        reg_writes++;
    endtask

    task automatic apply_setup(input int n, input int lo, input int hi, input int fs);
        settle();
        write_reg(REG_TARE_SAMPLES, CFG_DATA_W'(n));
        write_reg(REG_VOLT_MIN, CFG_DATA_W'(lo));
        write_reg(REG_VOLT_MAX, CFG_DATA_W'(hi));
        write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        cur_len = (n == 0) ? 1 : n;
        setup_count++;
    endtask

    // Random calibration, extremes and bad ranges included
    task automatic random_setup();
        int n;
        int lo;
        int hi;
        int fs;
        case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = 255;
            2:       n = 1;
            default: n = $urandom_range(2, 6);
        endcase
        case ($urandom_range(0, 7))
            0:
            begin
                lo = 0;
                hi = 65535;
            end
            1:
            begin
                lo = $urandom_range(0, 65535);
                hi = lo;
            end
            2:
            begin
                hi = $urandom_range(0, 60000);
                lo = hi + $urandom_range(1, 5535);
            end
            3:
            begin
                lo = $urandom_range(0, 65534);
                hi = lo + 1;
            end
            default:
            begin
                lo = $urandom_range(0, 30000);
                hi = lo + $urandom_range(1000, 35535);
            end
        endcase
        case ($urandom_range(0, 5))
            0:       fs = 0;
            1:       fs = 65535;
            default: fs = $urandom_range(1, 65535);
        endcase
        apply_setup(n, lo, hi, fs);
    endtask

    // Mostly tare runs around one level mixed with measure samples
    task automatic random_samples();
        int               count;
        int               run;
        logic [CH_W-1:0]  ch;
        logic [VOLT_W-1:0] base;
        count = 0;
        while (count < SAMPLES_PER_SETUP)
        begin
            ch = CH_W'($urandom_range(0, NUM_SENSORS_DEF - 1));
            if ($urandom_range(0, 9) < 4)
            begin
                run = $urandom_range(1, (cur_len > 7) ? 8 : cur_len + 1);
                base = pick_voltage();
                repeat (run)
                begin
                    send_sample(KIND_TARE, ch, nudge(base, 30));
                    count++;
                end
            end
            else
            begin
                send_sample(KIND_MEASURE, ch, pick_voltage());
                count++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_TARE;
        sensor <= '0;
        voltage <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TARE_SAMPLES;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // default calibration, no tare yet: zero point is volt_min
        send_sample(KIND_MEASURE, 2'd0, 16'd0);
        send_sample(KIND_MEASURE, 2'd1, 16'd65535);
        send_sample(KIND_MEASURE, 2'd2, 16'd5000);
        send_sample(KIND_MEASURE, 2'd3, 16'd45000);
        send_sample(KIND_TARE, 2'd0, 16'd65535);

        // zero sample count, one-step span: instant tares and overflow
        apply_setup(0, 0, 1, 65535);
        send_sample(KIND_TARE, 2'd1, 16'd0);
        send_sample(KIND_TARE, 2'd2, 16'd65535);
        send_sample(KIND_MEASURE, 2'd3, 16'd65535);
        send_sample(KIND_MEASURE, 2'd1, 16'd1);
        send_sample(KIND_MEASURE, 2'd2, 16'd65535);
        send_sample(KIND_TARE, 2'd0, 16'd1);

        // empty range
        apply_setup(255, 100, 100, 0);
        send_sample(KIND_MEASURE, 2'd0, 16'd200);

        // inverted range, then the target lowered in the middle of an average
        apply_setup(10, 65535, 0, 777);
        send_sample(KIND_MEASURE, 2'd1, 16'd30000);
        send_sample(KIND_TARE, 2'd3, 16'd1000);
        send_sample(KIND_TARE, 2'd3, 16'd1003);
        send_sample(KIND_TARE, 2'd3, 16'd1010);
        send_sample(KIND_TARE, 2'd3, 16'd997);
        send_sample(KIND_TARE, 2'd3, 16'd1001);
        apply_setup(3, 0, 65535, 0);
        send_sample(KIND_TARE, 2'd3, 16'd1002);
        send_sample(KIND_MEASURE, 2'd3, 16'd50000);

        // random calibrations
        repeat (RANDOM_SETUPS)
        begin
            random_setup();
            random_samples();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d tare and %0d measure samples over %0d calibrations, %0d reg writes.",
                 tare_sent, measure_sent, setup_count, reg_writes);
        $display("Checked %0d result beats against predicted pressures and tare levels.",
                 results_checked);
        if (mismatches == 0 && results_waiting == 0)
            $display("pressure_tare_and_scale_test passed");
        else
            $display("pressure_tare_and_scale_test failed");
        $finish;
    end

endmodule
